// ===== design/wodo_pkg.sv =====
// Shared constants, types and the CORDIC angle table for the wheel odometry integrator.
// No dependencies.
package wodo_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int POS_BITS     = 48;
    localparam int DT_FRAC_BITS = 20;
    localparam int TRIG_BITS    = 16;
    localparam int SPEED_W      = 24;
    localparam int RATE_W       = 24;
    localparam int DT_W         = 21;
    localparam int VEL_W        = 24;
    localparam int CORDIC_ITERS = 30;
    localparam int CNT_W        = 5;
    localparam int CW           = 34;
    localparam int MA_W         = 26;
    localparam int MB_W         = 22;
    localparam int MP_W         = MA_W + MB_W;
    localparam int TURN_W       = 32;

    localparam logic signed [CW-1:0] X_START = CW'(652032874);

    typedef enum logic [3:0] {
        S_IDLE,
        S_STEP,
        S_CSTEP,
        S_CHEAD,
        S_CHALF,
        S_VX,
        S_VY,
        S_P1,
        S_P2,
        S_P3,
        S_P4,
        S_DX,
        S_DY
    } state_t;

    typedef struct packed {
        logic              start;
        logic [TURN_W-1:0] turn;
    } cordic_req_t;

    typedef struct packed {
        logic                        done;
        logic signed [TRIG_BITS-1:0] cos_v;
        logic signed [TRIG_BITS-1:0] sin_v;
    } cordic_rsp_t;

    function automatic logic signed [CW-1:0] atan_turn(input logic [CNT_W-1:0] i);
        logic signed [CW-1:0] r;
        case (i)
            5'd0:    r = CW'(536870912);
            5'd1:    r = CW'(316933406);
            5'd2:    r = CW'(167458907);
            5'd3:    r = CW'(85004756);
            5'd4:    r = CW'(42667331);
            5'd5:    r = CW'(21354465);
            5'd6:    r = CW'(10679838);
            5'd7:    r = CW'(5340245);
            5'd8:    r = CW'(2670163);
            5'd9:    r = CW'(1335087);
            5'd10:   r = CW'(667544);
            5'd11:   r = CW'(333772);
            5'd12:   r = CW'(166886);
            5'd13:   r = CW'(83443);
            5'd14:   r = CW'(41722);
            5'd15:   r = CW'(20861);
            5'd16:   r = CW'(10430);
            5'd17:   r = CW'(5215);
            5'd18:   r = CW'(2608);
            5'd19:   r = CW'(1304);
            5'd20:   r = CW'(652);
            5'd21:   r = CW'(326);
            5'd22:   r = CW'(163);
            5'd23:   r = CW'(81);
            5'd24:   r = CW'(41);
            5'd25:   r = CW'(20);
            5'd26:   r = CW'(10);
            5'd27:   r = CW'(5);
            5'd28:   r = CW'(3);
            5'd29:   r = CW'(1);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/wodo_if.sv =====
// Valid/ready channel interfaces: configuration, tick input and pose output.
// Depends on wodo_pkg.
interface wodo_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [wodo_pkg::ANGLE_BITS-1:0]  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface wodo_tick_if;
    logic                              valid;
    logic                              ready;
    logic signed [wodo_pkg::SPEED_W-1:0] speed;
    logic signed [wodo_pkg::RATE_W-1:0]  yaw_rate;
    logic [wodo_pkg::DT_W-1:0]           elapsed;
    modport source (output valid, output speed, output yaw_rate, output elapsed, input ready);
    modport sink (input valid, input speed, input yaw_rate, input elapsed, output ready);
endinterface

interface wodo_pose_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [wodo_pkg::POS_BITS-1:0]  pos_x;
    logic signed [wodo_pkg::POS_BITS-1:0]  pos_y;
    logic [wodo_pkg::ANGLE_BITS-1:0]       heading;
    logic signed [wodo_pkg::VEL_W-1:0]     vel_x;
    logic signed [wodo_pkg::VEL_W-1:0]     vel_y;
    logic signed [wodo_pkg::TRIG_BITS-1:0] quat_z;
    logic signed [wodo_pkg::TRIG_BITS-1:0] quat_w;
    logic                                  saturated;
    modport source (output valid, output pos_x, output pos_y, output heading, output vel_x,
                    output vel_y, output quat_z, output quat_w, output saturated, input ready);
    modport sink (input valid, input pos_x, input pos_y, input heading, input vel_x,
                  input vel_y, input quat_z, input quat_w, input saturated, output ready);
endinterface

// ===== design/wodo_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on wodo_pkg.
module wodo_mul (
    input  logic                             clk,
    input  logic signed [wodo_pkg::MA_W-1:0] a,
    input  logic signed [wodo_pkg::MB_W-1:0] b,
    output logic signed [wodo_pkg::MP_W-1:0] p
);
    logic signed [wodo_pkg::MP_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= wodo_pkg::MP_W'(a) * wodo_pkg::MP_W'(b);
    end

    assign p = p_reg;
endmodule

// ===== design/wodo_cordic.sv =====
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, sin/cos of a turn fraction.
// Depends on wodo_pkg.
module wodo_cordic (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wodo_pkg::cordic_req_t req,
    output wodo_pkg::cordic_rsp_t rsp
);
    localparam int CW = wodo_pkg::CW;
    localparam int SH = 31 - wodo_pkg::TRIG_BITS;
    localparam logic signed [CW-1:0] QUARTER = CW'(64'sd1 << 30);
    localparam logic signed [CW-1:0] HALF    = CW'(64'sd1 << 31);
    localparam logic signed [CW-1:0] RND     = CW'(64'sd1 << (SH - 1));
    localparam logic signed [CW-1:0] TMAX    = CW'((64'sd1 << (wodo_pkg::TRIG_BITS - 1)) - 1);
    localparam logic signed [CW-1:0] TMIN    = -TMAX - CW'(1);

    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic [wodo_pkg::CNT_W-1:0] cnt_reg;
    logic run_reg, done_reg, neg_reg;
    logic signed [CW-1:0] z0, xs, ys, xv, yv, xr, yr;

    assign z0 = CW'(signed'(req.turn));
    assign xs = x_reg >>> cnt_reg;
    assign ys = y_reg >>> cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == wodo_pkg::CNT_W'(wodo_pkg::CORDIC_ITERS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg <= wodo_pkg::X_START;
            y_reg <= '0;
            if (z0 > QUARTER)
            begin
                z_reg   <= z0 - HALF;
                neg_reg <= 1'b1;
            end
            else if (z0 < -QUARTER)
            begin
                z_reg   <= z0 + HALF;
                neg_reg <= 1'b1;
            end
            else
            begin
                z_reg   <= z0;
                neg_reg <= 1'b0;
            end
        end
        else if (run_reg)
        begin
            if (!z_reg[CW-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - wodo_pkg::atan_turn(cnt_reg);
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + wodo_pkg::atan_turn(cnt_reg);
            end
        end
    end

    assign xv = neg_reg ? -x_reg : x_reg;
    assign yv = neg_reg ? -y_reg : y_reg;
    assign xr = (xv + RND) >>> SH;
    assign yr = (yv + RND) >>> SH;

    always_comb
    begin
        rsp.done  = done_reg;
        rsp.cos_v = (xr > TMAX) ? TMAX[wodo_pkg::TRIG_BITS-1:0] :
                    (xr < TMIN) ? TMIN[wodo_pkg::TRIG_BITS-1:0] : xr[wodo_pkg::TRIG_BITS-1:0];
        rsp.sin_v = (yr > TMAX) ? TMAX[wodo_pkg::TRIG_BITS-1:0] :
                    (yr < TMIN) ? TMIN[wodo_pkg::TRIG_BITS-1:0] : yr[wodo_pkg::TRIG_BITS-1:0];
    end
endmodule

// ===== design/wheel_odometry_integrator.sv =====
// Dead-reckoning odometry: one tick in, one pose item out, using a shared CORDIC and multiplier.
// Steps from tick accept to pose valid: a step state, three CORDIC runs (step, heading and
// half heading), then the multiply/accumulate states for velocity, rotation and position.
// A new tick is taken only when idle with no pose waiting, so ticks do not overlap.
// Reset (rst_n, async, active low) clears heading and both positions; a config write loads heading.
// Depends on wodo_pkg, wodo_if, wodo_mul and wodo_cordic.
module wheel_odometry_integrator (
    input logic              clk,
    input logic              rst_n,
    wodo_cfg_if.sink         cfg,
    wodo_tick_if.sink        tick,
    wodo_pose_if.source      pose
);
    localparam int AB = wodo_pkg::ANGLE_BITS;
    localparam int TB = wodo_pkg::TRIG_BITS;
    localparam int DB = wodo_pkg::DT_FRAC_BITS;
    localparam int PB = wodo_pkg::POS_BITS;
    localparam int MP = wodo_pkg::MP_W;
    localparam int VW = wodo_pkg::VEL_W;
    localparam int SW = PB + 2;
    localparam logic signed [MP-1:0] RND_T = MP'(64'sd1 << (TB - 2));
    localparam logic signed [MP:0]   RND_T1 = (MP + 1)'(64'sd1 << (TB - 2));
    localparam logic signed [MP-1:0] RND_D = MP'(64'sd1 << (DB - 1));
    localparam logic signed [MP-1:0] VMAX = MP'((64'sd1 << (VW - 1)) - 1);
    localparam logic signed [MP-1:0] VMIN = -VMAX - MP'(1);
    localparam logic signed [SW-1:0] PMAX = SW'((65'sd1 <<< (PB - 1)) - 1);
    localparam logic signed [SW-1:0] PMIN = -PMAX - SW'(1);

    wodo_pkg::state_t state_reg, state_next;
    wodo_pkg::cordic_req_t creq;
    wodo_pkg::cordic_rsp_t crsp;

    logic signed [wodo_pkg::MA_W-1:0] mul_a;
    logic signed [wodo_pkg::MB_W-1:0] mul_b;
    logic signed [MP-1:0] prod;

    logic signed [wodo_pkg::SPEED_W-1:0] speed_reg;
    logic [wodo_pkg::DT_W-1:0]           elapsed_reg;
    logic [AB-1:0]                       heading_reg;
    logic signed [PB-1:0]                pos_x_reg, pos_y_reg;
    logic signed [TB-1:0] dc_reg, ds_reg, hc_reg, hs_reg, qc_reg, qs_reg;
    logic signed [VW-1:0] vx_reg, vy_reg;
    logic signed [MP-1:0] acc_reg;
    logic signed [wodo_pkg::MA_W-1:0] rx_reg, ry_reg;
    logic out_valid_reg, sat_reg;

    logic [AB-1:0]          step;
    logic signed [MP-1:0]   sum_d, vrnd, drnd;
    logic signed [MP:0]     rsum;
    logic signed [VW-1:0]   vclip;
    logic signed [SW-1:0]   pos_sum;
    logic signed [PB-1:0]   pos_clip;
    logic                   pos_ovf;
    logic signed [wodo_pkg::MB_W-1:0] dt_op;

    assign sum_d = prod + RND_D;
    assign step  = sum_d[DB+AB-1:DB];
    assign vrnd  = (prod + RND_T) >>> (TB - 1);
    assign vclip = (vrnd > VMAX) ? VMAX[VW-1:0] : (vrnd < VMIN) ? VMIN[VW-1:0] : vrnd[VW-1:0];
    assign rsum  = ((state_reg == wodo_pkg::S_P2) ? ((MP + 1)'(acc_reg) - (MP + 1)'(prod))
                                                  : ((MP + 1)'(acc_reg) + (MP + 1)'(prod)))
                   + RND_T1;
    assign drnd  = sum_d >>> DB;
    assign pos_sum = ((state_reg == wodo_pkg::S_DX) ? SW'(pos_x_reg) : SW'(pos_y_reg)) + SW'(drnd);
    assign pos_ovf = (pos_sum > PMAX) || (pos_sum < PMIN);
    assign pos_clip = (pos_sum > PMAX) ? PMAX[PB-1:0] :
                      (pos_sum < PMIN) ? PMIN[PB-1:0] : pos_sum[PB-1:0];
    assign dt_op = signed'(wodo_pkg::MB_W'(elapsed_reg));

    wodo_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    wodo_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (creq),
        .rsp   (crsp)
    );

    assign tick.ready = (state_reg == wodo_pkg::S_IDLE) && !out_valid_reg;
    assign cfg.ready  = (state_reg == wodo_pkg::S_IDLE) && !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wodo_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        creq.start = 1'b0;
        creq.turn  = '0;
        mul_a      = '0;
        mul_b      = '0;
        case (state_reg)
            wodo_pkg::S_IDLE:
            begin
                mul_a = wodo_pkg::MA_W'(tick.yaw_rate);
                mul_b = signed'(wodo_pkg::MB_W'(tick.elapsed));
                if (tick.valid && tick.ready)
                begin
                    state_next = wodo_pkg::S_STEP;
                end
            end
            wodo_pkg::S_STEP:
            begin
                creq.start = 1'b1;
                creq.turn  = {step, (wodo_pkg::TURN_W - AB)'(0)};
                state_next = wodo_pkg::S_CSTEP;
            end
            wodo_pkg::S_CSTEP:
            begin
                if (crsp.done)
                begin
                    creq.start = 1'b1;
                    creq.turn  = {heading_reg, (wodo_pkg::TURN_W - AB)'(0)};
                    state_next = wodo_pkg::S_CHEAD;
                end
            end
            wodo_pkg::S_CHEAD:
            begin
                if (crsp.done)
                begin
                    creq.start = 1'b1;
                    creq.turn  = {1'b0, heading_reg, (wodo_pkg::TURN_W - AB - 1)'(0)};
                    state_next = wodo_pkg::S_CHALF;
                end
            end
            wodo_pkg::S_CHALF:
            begin
                mul_a = wodo_pkg::MA_W'(speed_reg);
                mul_b = wodo_pkg::MB_W'(dc_reg);
                if (crsp.done)
                begin
                    state_next = wodo_pkg::S_VX;
                end
            end
            wodo_pkg::S_VX:
            begin
                mul_a = wodo_pkg::MA_W'(speed_reg);
                mul_b = wodo_pkg::MB_W'(ds_reg);
                state_next = wodo_pkg::S_VY;
            end
            wodo_pkg::S_VY:
            begin
                mul_a = wodo_pkg::MA_W'(vx_reg);
                mul_b = wodo_pkg::MB_W'(hc_reg);
                state_next = wodo_pkg::S_P1;
            end
            wodo_pkg::S_P1:
            begin
                mul_a = wodo_pkg::MA_W'(vy_reg);
                mul_b = wodo_pkg::MB_W'(hs_reg);
                state_next = wodo_pkg::S_P2;
            end
            wodo_pkg::S_P2:
            begin
                mul_a = wodo_pkg::MA_W'(vx_reg);
                mul_b = wodo_pkg::MB_W'(hs_reg);
                state_next = wodo_pkg::S_P3;
            end
            wodo_pkg::S_P3:
            begin
                mul_a = wodo_pkg::MA_W'(vy_reg);
                mul_b = wodo_pkg::MB_W'(hc_reg);
                state_next = wodo_pkg::S_P4;
            end
            wodo_pkg::S_P4:
            begin
                mul_a = rx_reg;
                mul_b = dt_op;
                state_next = wodo_pkg::S_DX;
            end
            wodo_pkg::S_DX:
            begin
                mul_a = ry_reg;
                mul_b = dt_op;
                state_next = wodo_pkg::S_DY;
            end
            wodo_pkg::S_DY:
            begin
                state_next = wodo_pkg::S_IDLE;
            end
            default:
            begin
                state_next = wodo_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heading_reg   <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pose.valid && pose.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.valid && cfg.ready)
            begin
                heading_reg <= cfg.data;
            end
            case (state_reg)
                wodo_pkg::S_STEP:
                begin
                    heading_reg <= heading_reg + step;
                end
                wodo_pkg::S_DX:
                begin
                    pos_x_reg <= pos_clip;
                end
                wodo_pkg::S_DY:
                begin
                    pos_y_reg     <= pos_clip;
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            wodo_pkg::S_IDLE:
            begin
                if (tick.valid && tick.ready)
                begin
                    speed_reg   <= tick.speed;
                    elapsed_reg <= tick.elapsed;
                end
            end
            wodo_pkg::S_CSTEP:
            begin
                if (crsp.done)
                begin
                    dc_reg <= crsp.cos_v;
                    ds_reg <= crsp.sin_v;
                end
            end
            wodo_pkg::S_CHEAD:
            begin
                if (crsp.done)
                begin
                    hc_reg <= crsp.cos_v;
                    hs_reg <= crsp.sin_v;
                end
            end
            wodo_pkg::S_CHALF:
            begin
                if (crsp.done)
                begin
                    qc_reg <= crsp.cos_v;
                    qs_reg <= crsp.sin_v;
                end
            end
            wodo_pkg::S_VX:
            begin
                vx_reg <= vclip;
            end
            wodo_pkg::S_VY:
            begin
                vy_reg <= vclip;
            end
            wodo_pkg::S_P1, wodo_pkg::S_P3:
            begin
                acc_reg <= prod;
            end
            wodo_pkg::S_P2:
            begin
                rx_reg <= wodo_pkg::MA_W'(rsum >>> (TB - 1));
            end
            wodo_pkg::S_P4:
            begin
                ry_reg <= wodo_pkg::MA_W'(rsum >>> (TB - 1));
            end
            wodo_pkg::S_DX:
            begin
                sat_reg <= pos_ovf;
            end
            wodo_pkg::S_DY:
            begin
                sat_reg <= sat_reg | pos_ovf;
            end
            default:
            begin
            end
        endcase
    end

    assign pose.valid     = out_valid_reg;
    assign pose.pos_x     = pos_x_reg;
    assign pose.pos_y     = pos_y_reg;
    assign pose.heading   = heading_reg;
    assign pose.vel_x     = vx_reg;
    assign pose.vel_y     = vy_reg;
    assign pose.quat_z    = qs_reg;
    assign pose.quat_w    = qc_reg;
    assign pose.saturated = sat_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        tick.ready |-> !out_valid_reg && (state_reg == wodo_pkg::S_IDLE))
        else $error("tick ready while busy");

    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (pose.valid && pose.ready) |=> !pose.valid)
        else $error("result repeated after handshake");

    a_sat_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (pose.valid && pose.saturated) |->
            (pos_x_reg == PMAX[PB-1:0]) || (pos_x_reg == PMIN[PB-1:0]) ||
            (pos_y_reg == PMAX[PB-1:0]) || (pos_y_reg == PMIN[PB-1:0]))
        else $error("saturated flag without clipped position");

    a_cordic_done: assert property (@(posedge clk) disable iff (!rst_n)
        crsp.done |-> (state_reg == wodo_pkg::S_CSTEP) || (state_reg == wodo_pkg::S_CHEAD) ||
                      (state_reg == wodo_pkg::S_CHALF))
        else $error("cordic done outside a wait state");
endmodule

// ===== dv/wodo_test_pkg.sv =====
// Scoreboard for the wheel odometry integrator: pose predictor and queue of expected poses.
// Depends on wodo_pkg.
package wodo_test_pkg;
    import wodo_pkg::*;

    typedef struct {
        logic signed [POS_BITS-1:0]  pos_x;
        logic signed [POS_BITS-1:0]  pos_y;
        logic [ANGLE_BITS-1:0]       heading;
        logic signed [VEL_W-1:0]     vel_x;
        logic signed [VEL_W-1:0]     vel_y;
        logic signed [TRIG_BITS-1:0] quat_z;
        logic signed [TRIG_BITS-1:0] quat_w;
        logic                        saturated;
    } pose_t;

    class odo_scoreboard;
        logic [ANGLE_BITS-1:0] heading_q;
        longint pos_x_q, pos_y_q;
        pose_t  pending[$];
        int     errors, ticks, poses, sat_seen;

        function new();
            heading_q = '0;
            pos_x_q = 0;
            pos_y_q = 0;
            errors = 0;
            ticks = 0;
            poses = 0;
            sat_seen = 0;
        endfunction

        function void load_heading(logic [ANGLE_BITS-1:0] h);
            heading_q = h;
        endfunction

        static function longint round_shift(longint v, int n);
            return (v + (longint'(1) <<< (n - 1))) >>> n;
        endfunction

        static function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        static function void cordic(logic [31:0] turn, output longint c, output longint s);
            longint z, x, y, t, tmax;
            bit neg;
            z = longint'(signed'(turn));
            x = 652032874;
            y = 0;
            neg = 0;
            tmax = (longint'(1) << (TRIG_BITS - 1)) - 1;
            if (z > (longint'(1) << 30)) begin z -= longint'(1) << 31; neg = 1; end
            else if (z < -(longint'(1) << 30)) begin z += longint'(1) << 31; neg = 1; end
            for (int i = 0; i < CORDIC_ITERS; i++)
            begin
                if (z >= 0)
                begin
                    t = x - (y >>> i); y = y + (x >>> i); x = t;
                    z -= longint'(atan_turn(i[CNT_W-1:0]));
                end
                else
                begin
                    t = x + (y >>> i); y = y - (x >>> i); x = t;
                    z += longint'(atan_turn(i[CNT_W-1:0]));
                end
            end
            if (neg) begin x = -x; y = -y; end
            c = clip(round_shift(x, 31 - TRIG_BITS), -tmax - 1, tmax);
            s = clip(round_shift(y, 31 - TRIG_BITS), -tmax - 1, tmax);
        endfunction

        function longint add_clip(longint acc, longint d, ref bit sat);
            longint hi, sum;
            hi = (longint'(1) << (POS_BITS - 1)) - 1;
            sum = acc + d;
            if (sum > hi) begin sat = 1; return hi; end
            if (sum < -hi - 1) begin sat = 1; return -hi - 1; end
            return sum;
        endfunction

        function void note_tick(logic signed [SPEED_W-1:0] spd, logic signed [RATE_W-1:0] rate,
                                logic [DT_W-1:0] dt);
            longint dc, ds, hc, hs, qc, qs, vx, vy, rx, ry, e;
            logic [ANGLE_BITS-1:0] step;
            bit sat;
            pose_t p;
            sat = 0;
            e = longint'(dt);
            step = ANGLE_BITS'(round_shift(longint'(rate) * e, DT_FRAC_BITS));
            heading_q = heading_q + step;
            cordic({step, 16'h0}, dc, ds);
            vx = clip(round_shift(longint'(spd) * dc, TRIG_BITS - 1), -8388608, 8388607);
            vy = clip(round_shift(longint'(spd) * ds, TRIG_BITS - 1), -8388608, 8388607);
            cordic({heading_q, 16'h0}, hc, hs);
            rx = round_shift(vx * hc - vy * hs, TRIG_BITS - 1);
            ry = round_shift(vx * hs + vy * hc, TRIG_BITS - 1);
            pos_x_q = add_clip(pos_x_q, round_shift(rx * e, DT_FRAC_BITS), sat);
            pos_y_q = add_clip(pos_y_q, round_shift(ry * e, DT_FRAC_BITS), sat);
            cordic({1'b0, heading_q, 15'h0}, qc, qs);
            p.pos_x = pos_x_q[POS_BITS-1:0];
            p.pos_y = pos_y_q[POS_BITS-1:0];
            p.heading = heading_q;
            p.vel_x = vx[VEL_W-1:0];
            p.vel_y = vy[VEL_W-1:0];
            p.quat_z = qs[TRIG_BITS-1:0];
            p.quat_w = qc[TRIG_BITS-1:0];
            p.saturated = sat;
            pending.push_back(p);
            ticks++;
        endfunction

        function void check_pose(pose_t a);
            pose_t x;
            poses++;
            if (a.saturated) sat_seen++;
            if (pending.size() == 0)
            begin
                $error("pose item with none expected");
                errors++;
                return;
            end
            x = pending.pop_front();
            if (a.pos_x !== x.pos_x)
            begin $error("pos_x exp %0d got %0d", x.pos_x, a.pos_x); errors++; end
            if (a.pos_y !== x.pos_y)
            begin $error("pos_y exp %0d got %0d", x.pos_y, a.pos_y); errors++; end
            if (a.heading !== x.heading)
            begin $error("heading exp %0d got %0d", x.heading, a.heading); errors++; end
            if (a.vel_x !== x.vel_x)
            begin $error("vel_x exp %0d got %0d", x.vel_x, a.vel_x); errors++; end
            if (a.vel_y !== x.vel_y)
            begin $error("vel_y exp %0d got %0d", x.vel_y, a.vel_y); errors++; end
            if (a.quat_z !== x.quat_z)
            begin $error("quat_z exp %0d got %0d", x.quat_z, a.quat_z); errors++; end
            if (a.quat_w !== x.quat_w)
            begin $error("quat_w exp %0d got %0d", x.quat_w, a.quat_w); errors++; end
            if (a.saturated !== x.saturated)
            begin $error("saturated exp %0d got %0d", x.saturated, a.saturated); errors++; end
        endfunction
    endclass
endpackage

// ===== dv/wheel_odometry_integrator_test.sv =====
// Top-level test for wheel_odometry_integrator: directed and random ticks, heading presets.
// Depends on wodo_pkg, wodo_if, wodo_test_pkg and the design.
module wheel_odometry_integrator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import wodo_pkg::*;
    import wodo_test_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    wodo_cfg_if  cfg();
    wodo_tick_if tick();
    wodo_pose_if pose();

    odo_scoreboard sb = new();
    bit hold_pose = 0;
    bit stim_done = 0;
    int idle_cycles = 0;
    int cfg_writes = 0;

    wheel_odometry_integrator dut (.clk(clk), .rst_n(rst_n), .cfg(cfg), .tick(tick), .pose(pose));

    always #6 clk = ~clk;

    initial
    begin
        cfg.valid = 1'b0;
        cfg.data = '0;
        tick.valid = 1'b0;
        tick.speed = '0;
        tick.yaw_rate = '0;
        tick.elapsed = '0;
        pose.ready = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pose.valid && pose.ready)
                sb.check_pose('{pose.pos_x, pose.pos_y, pose.heading, pose.vel_x, pose.vel_y,
                                pose.quat_z, pose.quat_w, pose.saturated});
            pose.ready <= !hold_pose && ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !((tick.valid && tick.ready) || (pose.valid && pose.ready)
                       || (cfg.valid && cfg.ready)))
            idle_cycles <= idle_cycles + 1;
        else
            idle_cycles <= 0;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("wheel_odometry_integrator_test: done, errors");
            $finish;
        end
    end

    // the block is busy after an accept until its pose is taken, so the wait before each item is free
    task automatic send_tick(logic signed [SPEED_W-1:0] s, logic signed [RATE_W-1:0] r,
                             logic [DT_W-1:0] e, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        repeat (g + 1) @(posedge clk);
        tick.valid <= 1'b1;
        tick.speed <= s;
        tick.yaw_rate <= r;
        tick.elapsed <= e;
        do @(posedge clk); while (!tick.ready);
        sb.note_tick(s, r, e);
        tick.valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_heading(logic [ANGLE_BITS-1:0] h);
        drain();
        cfg.valid <= 1'b1;
        cfg.data <= h;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        sb.load_heading(h);
        cfg_writes++;
    endtask

    function automatic logic [DT_W-1:0] rand_dt();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return DT_W'($urandom_range(0, 2097151));
        if (r == 1) return DT_W'(1048576);
        return DT_W'($urandom_range(0, 20000));
    endfunction

    task automatic random_phase(int n);
        logic signed [SPEED_W-1:0] s;
        logic signed [RATE_W-1:0] r;
        for (int i = 0; i < n; i++)
        begin
            s = $urandom_range(0, 3) == 0 ? SPEED_W'($urandom)
                                          : SPEED_W'($urandom_range(0, 8000000) - 4000000);
            r = RATE_W'($urandom);
            send_tick(s, r, rand_dt(), 1);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: extremes, wraps, zero dt, dt beyond one second
        send_tick('0, '0, '0, 0);
        send_tick(24'sh7FFFFF, 24'sh7FFFFF, 21'd1048576, 0);
        send_tick(24'sh800000, 24'sh800000, 21'd1048576, 0);
        send_tick(24'sh800000, 24'sh000000, 21'h1FFFFF, 0);
        send_tick(24'sh7FFFFF, 24'sh008000, 21'd1048576, 0);
        send_tick(24'sh800000, 24'sh7FFFFF, 21'h1FFFFF, 0);
        send_tick(24'sh123456, -24'sd1, 21'd1, 0);
        send_tick(24'sh7FFFFF, 24'sh004000, 21'd1048576, 0);
        write_heading(16'h8000);
        send_tick(24'sh800000, 24'sh0, 21'd1000, 0);
        send_tick(24'sh7FFFFF, 24'sh7FFFFF, 21'h1FFFFF, 0);
        write_heading(16'hFFFF);
        send_tick(24'sh400000, 24'sh000001, 21'd1048576, 0);
        write_heading(16'h0000);
        // drive straight at full speed with the longest dt; the positions stay far from saturation
        for (int i = 0; i < 12; i++)
            send_tick(24'sh7FFFFF, 24'sh0, 21'h1FFFFF, 0);
        write_heading(16'h4000);
        random_phase(250);
        // long receiver hold-off while ticks keep coming
        fork
            begin
                hold_pose = 1;
                repeat (800) @(posedge clk);
                hold_pose = 0;
            end
            random_phase(20);
        join
        drain();
        write_heading(16'(($urandom)));
        random_phase(230);
        write_heading(16'hC000);
        random_phase(230);
        drain();
        stim_done = 1;
        $display("ticks sent %0d, poses checked %0d, saturating poses %0d, heading writes %0d",
                 sb.ticks, sb.poses, sb.sat_seen, cfg_writes);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("wheel_odometry_integrator_test: done, clean");
        else
            $display("wheel_odometry_integrator_test: done, errors");
        $finish;
    end
endmodule
